>>> rtl/b64enc_pkg.sv
// ----------------------------------------------------------------------------
// b64enc_pkg
// Shared types, constants and the alphabet lookup of the base64 encoder.
// ----------------------------------------------------------------------------
package b64enc_pkg;

    localparam logic [7:0] LINE_LENGTH_RESET = 8'd76;
    localparam logic [7:0] LINE_LENGTH_MIN   = 8'd3;
    localparam logic [7:0] CHAR_PAD          = 8'h3D;
    localparam logic [7:0] CHAR_NEWLINE      = 8'h0A;
    localparam int         QUEUE_DEPTH       = 2;
    localparam int         GROUP_CHARS       = 4;

    // Position of the next byte within its three-byte group.
    localparam logic [1:0] PHASE_FIRST  = 2'd0;
    localparam logic [1:0] PHASE_SECOND = 2'd1;
    localparam logic [1:0] PHASE_THIRD  = 2'd2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_of_run;
        logic       message_done;
    } out_word_t;

    // One accepted byte, already turned into its printable characters.
    typedef struct packed {
        logic [GROUP_CHARS-1:0][7:0] chars;
        logic [1:0]                  cnt_m1;
        logic                        last;
    } group_t;

    typedef enum logic [1:0] {
        BACK_CHAR,
        BACK_BREAK,
        BACK_FINAL
    } back_state_t;

    function automatic logic [7:0] sym_char(input logic [5:0] v);
        logic [7:0] w;
        logic [7:0] c;
        begin
            w = {2'b00, v};
            if (v < 6'd26)
            begin
                c = 8'd65 + w;
            end
            else if (v < 6'd52)
            begin
                c = 8'd71 + w;
            end
            else if (v < 6'd62)
            begin
                c = w - 8'd4;
            end
            else if (v == 6'd62)
            begin
                c = 8'd43;
            end
            else
            begin
                c = 8'd47;
            end
            return c;
        end
    endfunction

endpackage

>>> rtl/b64enc_front.sv
// ----------------------------------------------------------------------------
// b64enc_front
// Accepts message bytes and splits them into base64 characters and padding.
// ----------------------------------------------------------------------------
module b64enc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  b64enc_pkg::in_word_t in_data,
    input  logic                queue_full,
    output logic                push,
    output b64enc_pkg::group_t  group
);

    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic [3:0] carry_reg;
    logic [3:0] carry_next;
    logic [7:0] b;
    logic       last;

    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;
    assign b        = in_data.in_byte;
    assign last     = in_data.last_byte;

    always_comb
    begin
        group.chars  = {b64enc_pkg::GROUP_CHARS{b64enc_pkg::CHAR_PAD}};
        group.cnt_m1 = 2'd0;
        group.last   = last;
        phase_next   = phase_reg;
        carry_next   = carry_reg;
        case (phase_reg)
            b64enc_pkg::PHASE_SECOND:
            begin
                group.chars[0] = b64enc_pkg::sym_char({carry_reg[1:0], b[7:4]});
                group.chars[1] = b64enc_pkg::sym_char({b[3:0], 2'b00});
                group.cnt_m1   = last ? 2'd2 : 2'd0;
                carry_next     = b[3:0];
                phase_next     = b64enc_pkg::PHASE_THIRD;
            end
            b64enc_pkg::PHASE_THIRD:
            begin
                group.chars[0] = b64enc_pkg::sym_char({carry_reg, b[7:6]});
                group.chars[1] = b64enc_pkg::sym_char(b[5:0]);
                group.cnt_m1   = 2'd1;
                carry_next     = 4'd0;
                phase_next     = b64enc_pkg::PHASE_FIRST;
            end
            default:
            begin
                // A group start; the unused phase code behaves the same way.
                group.chars[0] = b64enc_pkg::sym_char(b[7:2]);
                group.chars[1] = b64enc_pkg::sym_char({b[1:0], 4'b0000});
                group.cnt_m1   = last ? 2'd3 : 2'd0;
                carry_next     = {2'b00, b[1:0]};
                phase_next     = b64enc_pkg::PHASE_SECOND;
            end
        endcase
        if (last)
        begin
            carry_next = 4'd0;
            phase_next = b64enc_pkg::PHASE_FIRST;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= b64enc_pkg::PHASE_FIRST;
            carry_reg <= 4'd0;
        end
        else if (push)
        begin
            phase_reg <= phase_next;
            carry_reg <= carry_next;
        end
    end

endmodule

>>> rtl/b64enc_queue.sv
// ----------------------------------------------------------------------------
// b64enc_queue
// Short first-in first-out queue of character groups between the two halves.
// ----------------------------------------------------------------------------
module b64enc_queue #(
    parameter int DEPTH = b64enc_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  b64enc_pkg::group_t wr_group,
    input  logic               pop,
    output logic               full,
    output logic               not_empty,
    output b64enc_pkg::group_t rd_group
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    b64enc_pkg::group_t entries [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign rd_group  = entries[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= wr_group;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

endmodule

>>> rtl/b64enc_back.sv
// ----------------------------------------------------------------------------
// b64enc_back
// One char per cycle if not stalled; tracks line column and adds newlines.
// ----------------------------------------------------------------------------
module b64enc_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [7:0]            line_length,
    input  logic                  head_valid,
    input  b64enc_pkg::group_t    head,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output b64enc_pkg::out_word_t out_data
);

    b64enc_pkg::back_state_t state_reg;
    b64enc_pkg::back_state_t state_next;

    logic [1:0]            idx_reg;
    logic [1:0]            idx_next;
    logic [7:0]            col_reg;
    logic [7:0]            col_next;
    logic                  out_valid_reg;
    b64enc_pkg::out_word_t out_word_reg;
    b64enc_pkg::out_word_t emit_word;

    logic [7:0] eff_len;
    logic [7:0] col_inc;
    logic       breaks_on;
    logic       brk;
    logic       end_chars;
    logic       fin;
    logic       go;

    // Line lengths of one and two behave as three.
    always_comb
    begin
        eff_len = line_length;
        if (line_length != 8'd0 && line_length < b64enc_pkg::LINE_LENGTH_MIN)
        begin
            eff_len = b64enc_pkg::LINE_LENGTH_MIN;
        end
    end

    assign breaks_on = (eff_len != 8'd0);
    assign col_inc   = col_reg + 8'd1;
    assign brk       = breaks_on && (col_inc >= eff_len);
    assign end_chars = (idx_reg == head.cnt_m1);
    assign fin       = head.last && breaks_on && !brk;
    assign go        = head_valid && (!out_valid_reg || out_ready);

    // Next state, character index and column.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        col_next   = col_reg;
        if (go)
        begin
            case (state_reg)
                b64enc_pkg::BACK_CHAR:
                begin
                    col_next = (!breaks_on || brk) ? 8'd0 : col_inc;
                    if (brk)
                    begin
                        state_next = b64enc_pkg::BACK_BREAK;
                    end
                    else if (end_chars && fin)
                    begin
                        state_next = b64enc_pkg::BACK_FINAL;
                    end
                    else if (end_chars)
                    begin
                        idx_next = 2'd0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 2'd1;
                    end
                end
                b64enc_pkg::BACK_BREAK:
                begin
                    state_next = b64enc_pkg::BACK_CHAR;
                    col_next   = 8'd0;
                    idx_next   = end_chars ? 2'd0 : idx_reg + 2'd1;
                end
                b64enc_pkg::BACK_FINAL:
                begin
                    state_next = b64enc_pkg::BACK_CHAR;
                    col_next   = 8'd0;
                    idx_next   = 2'd0;
                end
                default:
                begin
                    state_next = b64enc_pkg::BACK_CHAR;
                    idx_next   = 2'd0;
                end
            endcase
        end
    end

    // Emitted word and queue pop.
    always_comb
    begin
        emit_word = '0;
        pop       = 1'b0;
        case (state_reg)
            b64enc_pkg::BACK_CHAR:
            begin
                emit_word.out_char     = head.chars[idx_reg];
                emit_word.last_of_run  = end_chars && !brk && !fin;
                emit_word.message_done = end_chars && !brk && !fin && head.last;
                pop                    = go && end_chars && !brk && !fin;
            end
            b64enc_pkg::BACK_BREAK:
            begin
                emit_word.out_char     = b64enc_pkg::CHAR_NEWLINE;
                emit_word.last_of_run  = end_chars;
                emit_word.message_done = end_chars && head.last;
                pop                    = go && end_chars;
            end
            b64enc_pkg::BACK_FINAL:
            begin
                emit_word.out_char     = b64enc_pkg::CHAR_NEWLINE;
                emit_word.last_of_run  = 1'b1;
                emit_word.message_done = 1'b1;
                pop                    = go;
            end
            default:
            begin
                emit_word = '0;
                pop       = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= b64enc_pkg::BACK_CHAR;
            idx_reg       <= 2'd0;
            col_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            col_reg   <= col_next;
            if (go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            out_word_reg <= emit_word;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

endmodule

>>> rtl/base64_stream_encoder.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming base64 encoder with '=' padding and optional line wrapping.
// ----------------------------------------------------------------------------
// Usage:
// Message bytes enter on the in channel (valid/ready), one byte per word, with
// last_byte set on the final byte of a message. Encoded text leaves on the out
// channel (valid/ready), one ASCII character per word. last_of_run marks the
// final character caused by an input byte; message_done marks the final
// character of the whole message, which is the closing newline when one is
// produced.
// A byte is written into a queue entry; its characters then leave through the
// output register. The output side delivers one character per cycle while the
// receiver takes them; a byte yields one to six characters, about four per
// three bytes plus newlines; the back end's single output port sets that rate.
// A two-entry queue sits between the front end and the back end, so input is
// still taken while the receiver stalls until the queue fills; the output
// register holds its word stable until it is taken.
// Reset clears the group phase, carry bits, line column and queue, and sets
// line_length to 76, written via cfg_wr_en and cfg_wr_data; the user writes it
// only while idle; the block does not enforce that. Zero turns line breaks off.
// ----------------------------------------------------------------------------
module base64_stream_encoder #(
    parameter int QUEUE_DEPTH = b64enc_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  b64enc_pkg::in_word_t  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output b64enc_pkg::out_word_t out_data,
    input  logic                  cfg_wr_en,
    input  logic [7:0]            cfg_wr_data
);

    logic               queue_full;
    logic               queue_not_empty;
    logic               push;
    logic               pop;
    b64enc_pkg::group_t wr_group;
    b64enc_pkg::group_t head;
    logic [7:0]         line_length_reg;

    // The line length register takes effect on the next character emitted.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_length_reg <= b64enc_pkg::LINE_LENGTH_RESET;
        end
        else if (cfg_wr_en)
        begin
            line_length_reg <= cfg_wr_data;
        end
    end

    // The front end turns each byte into its characters and padding.
    b64enc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .queue_full (queue_full),
        .push       (push),
        .group      (wr_group)
    );

    b64enc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_group  (wr_group),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .rd_group  (head)
    );

    // The back end places the characters on lines.
    b64enc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .line_length (line_length_reg),
        .head_valid  (queue_not_empty),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

endmodule

>>> rtl/b64enc_checker.sv
// ----------------------------------------------------------------------------
// b64enc_checker
// Port-level assertions for the base64 stream encoder.
// ----------------------------------------------------------------------------
module b64enc_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  out_valid,
    input logic                  out_ready,
    input b64enc_pkg::out_word_t out_data
);

    logic [7:0] c;

    assign c = out_data.out_char;

    // A stalled output word stays in place.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output word changed while stalled");

    // The end of a message also ends the run of its last byte.
    a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.message_done |-> out_data.last_of_run)
        else $error("message_done without last_of_run");

    // Only alphabet characters, padding and newline leave the block.
    a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
                       (c >= 8'h30 && c <= 8'h39) || c == 8'h2B || c == 8'h2F ||
                       c == b64enc_pkg::CHAR_PAD || c == b64enc_pkg::CHAR_NEWLINE))
        else $error("character outside the output set");

    // Padding that closes a run can only close the message.
    a_pad_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && c == b64enc_pkg::CHAR_PAD && out_data.last_of_run
        |-> out_data.message_done)
        else $error("padding ended a run inside a message");

endmodule

bind base64_stream_encoder b64enc_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

>>> sim/base64_stream_encoder_tb.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder_tb
// Self-checking testbench of the streaming base64 encoder.
// Message bytes are sent with random bursts and gaps. Encoded characters are
// taken with a stall pattern of their own. Every character is checked against
// a behavioral encoder that follows the group phase, the carry bits and the
// line column. A short table of hand-picked bytes comes first. Random messages
// then follow under a sweep of line-length settings.
// ----------------------------------------------------------------------------
module base64_stream_encoder_tb;

    // Longest stretch without any accepted word before the run is abandoned.
    // The longest correct pause is the forced receiver hold-off, so this is many
    // times over.
    localparam int STALL_LIMIT      = 5000;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES      = 16;
    localparam int NUM_SETTINGS     = 8;
    localparam int BYTES_PER_SETTING = 60;
    localparam int NUM_ROWS         = 29;

    // The 64 symbols, first symbol in the top byte.
    localparam logic [64*8-1:0] B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // A directed row either sends one byte or writes line_length. Where the
    // characters are obvious by hand they are typed in, first character in
    // the highest nonzero byte; a zero field means the encoder model decides.
    typedef enum logic
    {
        ROW_BYTE,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [7:0]  value;
        logic        last;
        logic [47:0] typed;
    } row_t;

    localparam row_t DIRECTED_ROWS [NUM_ROWS] = '{
        // Line length 76 after reset: single-byte messages at both extremes.
        '{ROW_BYTE, 8'h00, 1'b1, "AA==\n"},
        '{ROW_BYTE, 8'hFF, 1'b1, "/w==\n"},
        // Two-byte message, one pad.
        '{ROW_BYTE, 8'h00, 1'b0, "A"},
        '{ROW_BYTE, 8'hFF, 1'b1, "P8=\n"},
        // Full group of ones, no pad.
        '{ROW_BYTE, 8'hFF, 1'b0, "/"},
        '{ROW_BYTE, 8'hFF, 1'b0, "/"},
        '{ROW_BYTE, 8'hFF, 1'b1, "//\n"},
        // Build a partial line, then shrink the line length under it so the
        // column is already past the new limit.
        '{ROW_BYTE, 8'h4D, 1'b0, 48'd0},
        '{ROW_BYTE, 8'h61, 1'b0, 48'd0},
        '{ROW_BYTE, 8'h6E, 1'b0, 48'd0},
        '{ROW_BYTE, 8'h00, 1'b0, 48'd0},
        '{ROW_BYTE, 8'h00, 1'b0, 48'd0},
        '{ROW_CFG,  8'd3,  1'b0, 48'd0},
        '{ROW_BYTE, 8'h80, 1'b1, 48'd0},
        // Line breaks off: no closing newline either.
        '{ROW_CFG,  8'd0,  1'b0, 48'd0},
        '{ROW_BYTE, 8'h00, 1'b1, "AA=="},
        '{ROW_BYTE, 8'hFB, 1'b0, 48'd0},
        '{ROW_BYTE, 8'hEF, 1'b0, 48'd0},
        '{ROW_BYTE, 8'hBE, 1'b1, 48'd0},
        // A length of one wraps as three: the worst case of six characters.
        '{ROW_CFG,  8'd1,  1'b0, 48'd0},
        '{ROW_BYTE, 8'h00, 1'b1, "AA=\n=\n"},
        '{ROW_BYTE, 8'hFF, 1'b0, 48'd0},
        '{ROW_BYTE, 8'hFF, 1'b0, 48'd0},
        '{ROW_BYTE, 8'hFF, 1'b1, 48'd0},
        '{ROW_CFG,  8'd2,  1'b0, 48'd0},
        '{ROW_BYTE, 8'h55, 1'b0, 48'd0},
        '{ROW_BYTE, 8'hAA, 1'b1, 48'd0},
        // Longest line.
        '{ROW_CFG,  8'd255, 1'b0, 48'd0},
        '{ROW_BYTE, 8'h00, 1'b1, "AA==\n"}
    };

    logic                  clk;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    logic                  in_ready;
    b64enc_pkg::in_word_t  in_data     = '0;
    logic                  out_valid;
    logic                  out_ready   = 1'b0;
    b64enc_pkg::out_word_t out_data;
    logic                  cfg_wr_en   = 1'b0;
    logic [7:0]            cfg_wr_data = 8'd0;

    // Mirror of the encoder state, advanced on every accepted byte word.
    logic [7:0] line_len;
    logic [1:0] grp_phase;
    logic [3:0] carry;
    logic [7:0] column;

    // Characters caused by the byte being accepted, and every character
    // still owed by the block, oldest first.
    b64enc_pkg::out_word_t byte_run[$];
    b64enc_pkg::out_word_t owed_chars[$];

    int error_count    = 0;
    int report_count   = 0;
    int bytes_sent     = 0;
    int messages_sent  = 0;
    int chars_checked  = 0;
    int settings_used  = 0;
    int stall_cycles   = 0;

    // Receiver hold-off requests from the stimulus and how many were served.
    int hold_off_asks  = 0;
    int hold_off_done  = 0;
    int hold_off_left  = 0;
    logic [15:0] ready_pattern = 16'hFFFF;
    int pattern_age    = 0;

    // The sender works in bursts; this counts words left in the current one.
    int burst_left     = 0;

    base64_stream_encoder DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Encoder model
    // ------------------------------------------------------------------------

    // Short line lengths wrap as the minimum so one byte never causes more
    // than six characters.
    function automatic logic [7:0] wrap_length();
        logic [7:0] n;
        n = line_len;
        if (n != 8'd0 && n < b64enc_pkg::LINE_LENGTH_MIN)
        begin
            n = b64enc_pkg::LINE_LENGTH_MIN;
        end
        return n;
    endfunction

    function automatic void run_push(input logic [7:0] ch);
        b64enc_pkg::out_word_t o;
        o.out_char     = ch;
        o.last_of_run  = 1'b0;
        o.message_done = 1'b0;
        byte_run.push_back(o);
    endfunction

    // One printable character, followed by a newline when the line is full.
    function automatic void text_char(input logic [7:0] ch);
        logic [7:0] n;
        n = wrap_length();
        run_push(ch);
        if (n == 8'd0)
        begin
            column = 8'd0;
        end
        else
        begin
            column = column + 8'd1;
            if (column >= n)
            begin
                run_push(b64enc_pkg::CHAR_NEWLINE);
                column = 8'd0;
            end
        end
    endfunction

    function automatic void sextet(input logic [5:0] v);
        text_char(B64_ALPHABET[(63 - int'(v)) * 8 +: 8]);
    endfunction

    // Fills byte_run with the characters of one byte and advances the state.
    // The unused phase value falls into the default branch, as the first
    // byte of a group.
    function automatic void encode_byte(input b64enc_pkg::in_word_t w);
        logic [7:0] b;
        b = w.in_byte;
        byte_run.delete();
        case (grp_phase)
            b64enc_pkg::PHASE_SECOND:
            begin
                sextet({carry[1:0], b[7:4]});
                carry     = b[3:0];
                grp_phase = b64enc_pkg::PHASE_THIRD;
                if (w.last_byte)
                begin
                    sextet({carry, 2'b00});
                    text_char(b64enc_pkg::CHAR_PAD);
                end
            end
            b64enc_pkg::PHASE_THIRD:
            begin
                sextet({carry, b[7:6]});
                sextet(b[5:0]);
                carry     = 4'd0;
                grp_phase = b64enc_pkg::PHASE_FIRST;
            end
            default:
            begin
                sextet(b[7:2]);
                carry     = {2'b00, b[1:0]};
                grp_phase = b64enc_pkg::PHASE_SECOND;
                if (w.last_byte)
                begin
                    sextet({carry[1:0], 4'b0000});
                    text_char(b64enc_pkg::CHAR_PAD);
                    text_char(b64enc_pkg::CHAR_PAD);
                end
            end
        endcase
        // A message that ends mid-line gets one closing newline, unless line
        // breaks are off. Either way the next byte starts a fresh message.
        if (w.last_byte)
        begin
            if (wrap_length() != 8'd0 && column != 8'd0)
            begin
                run_push(b64enc_pkg::CHAR_NEWLINE);
            end
            grp_phase = b64enc_pkg::PHASE_FIRST;
            carry     = 4'd0;
            column    = 8'd0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // Offers one byte word and holds it until taken. in_ready is sampled on
    // the falling edge, where it already shows the value the next rising
    // edge will see. The characters owed are booked at the accepting edge.
    task automatic send_byte(input b64enc_pkg::in_word_t w, input logic [47:0] typed);
        in_valid <= 1'b1;
        in_data  <= w;
        @(negedge clk);
        while (!in_ready)
        begin
            @(negedge clk);
        end
        @(posedge clk);
        encode_byte(w);
        if (typed != 48'd0)
        begin
            byte_run.delete();
            for (int k = 5; k >= 0; k--)
            begin
                if (typed[k*8 +: 8] != 8'd0)
                begin
                    run_push(typed[k*8 +: 8]);
                end
            end
        end
        byte_run[byte_run.size()-1].last_of_run  = 1'b1;
        byte_run[byte_run.size()-1].message_done = w.last_byte;
        foreach (byte_run[k])
        begin
            owed_chars.push_back(byte_run[k]);
        end
        bytes_sent++;
        if (w.last_byte)
        begin
            messages_sent++;
        end
    endtask

    // Between words: stay valid while the burst lasts, otherwise drop valid
    // for a random gap and start a new burst, now and then a long one.
    task automatic pace_sender();
        if (burst_left != 0)
        begin
            burst_left--;
        end
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            if ($urandom_range(0, 4) == 0)
            begin
                burst_left = $urandom_range(30, 60);
            end
            else
            begin
                burst_left = $urandom_range(1, 12);
            end
        end
    endtask

    // Stops offering and waits until every owed character has been taken.
    // The loop waits on the clock before it checks, so back-to-back writes never share a step.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (owed_chars.size() != 0);
    endtask

    // Every byte causes at least one character, so once nothing is owed the
    // block is idle and the register can be written.
    task automatic write_line_length(input logic [7:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        line_len = value;
        settings_used++;
    endtask

    // ------------------------------------------------------------------------
    // Receiver side
    // ------------------------------------------------------------------------

    // out_ready follows a rotating 16-bit pattern that is redrawn when pattern_age
    // runs out: sometimes always ready, sometimes sparse, sometimes dense. A
    // hold-off request pulls it low for a long stretch so the internal queue
    // fills and the input side stalls.
    always @(posedge clk)
    begin
        if (hold_off_left != 0)
        begin
            out_ready     <= 1'b0;
            hold_off_left <= hold_off_left - 1;
        end
        else if (hold_off_asks != hold_off_done)
        begin
            out_ready     <= 1'b0;
            hold_off_left <= LONG_HOLD_CYCLES;
            hold_off_done <= hold_off_done + 1;
        end
        else
        begin
            out_ready <= ready_pattern[0];
            if (pattern_age == 0)
            begin
                pattern_age <= 63;
                case ($urandom_range(0, 3))
                    0:       ready_pattern <= 16'hFFFF;
                    1:       ready_pattern <= 16'($urandom) | 16'h0001;
                    2:       ready_pattern <= 16'($urandom & $urandom) | 16'h0001;
                    default: ready_pattern <= ~16'($urandom & $urandom & $urandom);
                endcase
            end
            else
            begin
                pattern_age   <= pattern_age - 1;
                ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
            end
        end
    end

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic flag_error(input string what, input b64enc_pkg::out_word_t want,
                              input b64enc_pkg::out_word_t got);
        error_count++;
        if (report_count < 10)
        begin
            report_count++;
            $display("ERROR: %s: expected char %h run %b done %b, got char %h run %b done %b",
                     what, want.out_char, want.last_of_run, want.message_done,
                     got.out_char, got.last_of_run, got.message_done);
        end
    endtask

    // Output words are sampled on the falling edge; valid, ready and data
    // are stable there until the rising edge that takes the word.
    always @(negedge clk)
    begin : char_check
        b64enc_pkg::out_word_t want;
        if (out_valid && out_ready)
        begin
            chars_checked++;
            if (owed_chars.size() == 0)
            begin
                flag_error("character with nothing owed", '0, out_data);
            end
            else
            begin
                want = owed_chars.pop_front();
                if (out_data.out_char !== want.out_char ||
                    out_data.last_of_run !== want.last_of_run ||
                    out_data.message_done !== want.message_done)
                begin
                    flag_error("character mismatch", want, out_data);
                end
            end
        end
    end

    // Ends the run when no word moves on either side for too long.
    always @(negedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            stall_cycles = 0;
        end
        else
        begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no word moved for %0d cycles, %0d characters still owed",
                         STALL_LIMIT, owed_chars.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    initial
    begin
        b64enc_pkg::in_word_t w;
        logic [7:0]           sweep [NUM_SETTINGS];
        int                   msg_left;

        line_len  = b64enc_pkg::LINE_LENGTH_RESET;
        grp_phase = b64enc_pkg::PHASE_FIRST;
        carry     = 4'd0;
        column    = 8'd0;
        msg_left  = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table first, starting from the reset line length.
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            if (DIRECTED_ROWS[r].kind == ROW_CFG)
            begin
                write_line_length(DIRECTED_ROWS[r].value);
            end
            else
            begin
                w.in_byte   = DIRECTED_ROWS[r].value;
                w.last_byte = DIRECTED_ROWS[r].last;
                send_byte(w, DIRECTED_ROWS[r].typed);
                pace_sender();
            end
        end

        // Line-length sweep: the reset value, off, the short values that wrap
        // as three, the minimum, the maximum, and two random picks.
        sweep[0] = b64enc_pkg::LINE_LENGTH_RESET;
        sweep[1] = 8'd0;
        sweep[2] = 8'd1;
        sweep[3] = 8'd2;
        sweep[4] = b64enc_pkg::LINE_LENGTH_MIN;
        sweep[5] = 8'd255;
        sweep[6] = 8'($urandom_range(4, 20));
        sweep[7] = 8'($urandom_range(0, 255));

        // Messages run across setting changes on purpose, so some writes
        // land mid-line and mid-group.
        for (int s = 0; s < NUM_SETTINGS; s++)
        begin
            write_line_length(sweep[s]);
            for (int i = 0; i < BYTES_PER_SETTING; i++)
            begin
                if (msg_left == 0)
                begin
                    case ($urandom_range(0, 9)) inside
                        [0:5]:   msg_left = $urandom_range(1, 6);
                        [6:7]:   msg_left = $urandom_range(7, 20);
                        8:       msg_left = $urandom_range(21, 80);
                        default: msg_left = 1;
                    endcase
                end
                case ($urandom_range(0, 7))
                    0:       w.in_byte = 8'h00;
                    1:       w.in_byte = 8'hFF;
                    default: w.in_byte = 8'($urandom_range(0, 255));
                endcase
                w.last_byte = (msg_left == 1);
                msg_left--;
                send_byte(w, 48'd0);

                // Starve the receiver for a long stretch while bytes keep
                // coming, so the queue fills and in_ready drops.
                if (s == 2 && i == 10)
                begin
                    hold_off_asks++;
                end

                // Let the block empty out completely before going on.
                if (s == 4 && i == 30)
                begin
                    wait_drained();
                end
                else
                begin
                    pace_sender();
                end
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d bytes in %0d messages under %0d line-length writes.",
                 bytes_sent, messages_sent, settings_used);
        $display("Checked %0d characters, including a %0d-cycle receiver hold-off.",
                 chars_checked, LONG_HOLD_CYCLES);
        if (error_count == 0 && owed_chars.size() == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
